[rtl/core/fir181_pkg.sv]
// fir181_pkg: shared types and constants for the 181-tap fir filter
// holds the fixed tap table, result widths and the sequencer state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fir181_pkg;

    localparam int OUT_W     = 32;
    localparam int OUT_SHIFT = 16;
    localparam int COEF_W    = 16;
    localparam int TABLE_LEN = 181;

    // symmetric low-pass taps, center tap at index 90
    localparam logic signed [COEF_W-1:0] TAP_TABLE [0:TABLE_LEN-1] = '{
        -16'sd103,  -16'sd120,  -16'sd146,  -16'sd135,   -16'sd70,
         16'sd50,    16'sd209,   16'sd374,   16'sd506,    16'sd568,
         16'sd537,   16'sd419,   16'sd243,   16'sd57,    -16'sd87,
        -16'sd151,  -16'sd122,   -16'sd23,   16'sd103,    16'sd202,
         16'sd232,   16'sd178,    16'sd59,   -16'sd80,   -16'sd185,
        -16'sd212,  -16'sd148,   -16'sd18,   16'sd127,    16'sd227,
         16'sd238,   16'sd152,    -16'sd2,  -16'sd162,   -16'sd262,
        -16'sd257,  -16'sd144,    16'sd36,   16'sd212,    16'sd309,
         16'sd282,   16'sd136,   -16'sd77,  -16'sd271,   -16'sd363,
        -16'sd308,  -16'sd120,   16'sd130,   16'sd343,    16'sd425,
         16'sd333,    16'sd95,  -16'sd200,  -16'sd432,   -16'sd498,
        -16'sd358,   -16'sd57,   16'sd291,   16'sd543,    16'sd585,
         16'sd382,    -16'sd1,  -16'sd415,  -16'sd688,   -16'sd693,
        -16'sd402,    16'sd88,   16'sd589,   16'sd889,    16'sd838,
         16'sd421,  -16'sd226,  -16'sd852, -16'sd1188,  -16'sd1051,
        -16'sd435,   16'sd464,  16'sd1303,  16'sd1709,   16'sd1428,
         16'sd446,  -16'sd963, -16'sd2287, -16'sd2926,  -16'sd2384,
        -16'sd453,  16'sd2682,  16'sd6452, 16'sd10046,  16'sd12625,
         16'sd13562,
         16'sd12625, 16'sd10046, 16'sd6452, 16'sd2682,  -16'sd453,
        -16'sd2384, -16'sd2926, -16'sd2287,  -16'sd963,   16'sd446,
         16'sd1428,  16'sd1709,  16'sd1303,   16'sd464,  -16'sd435,
        -16'sd1051, -16'sd1188,  -16'sd852,  -16'sd226,   16'sd421,
         16'sd838,   16'sd889,   16'sd589,    16'sd88,   -16'sd402,
        -16'sd693,  -16'sd688,  -16'sd415,    -16'sd1,    16'sd382,
         16'sd585,   16'sd543,   16'sd291,   -16'sd57,   -16'sd358,
        -16'sd498,  -16'sd432,  -16'sd200,    16'sd95,    16'sd333,
         16'sd425,   16'sd343,   16'sd130,  -16'sd120,   -16'sd308,
        -16'sd363,  -16'sd271,   -16'sd77,   16'sd136,    16'sd282,
         16'sd309,   16'sd212,    16'sd36,  -16'sd144,   -16'sd257,
        -16'sd262,  -16'sd162,    -16'sd2,   16'sd152,    16'sd238,
         16'sd227,   16'sd127,   -16'sd18,  -16'sd148,   -16'sd212,
        -16'sd185,   -16'sd80,    16'sd59,   16'sd178,    16'sd232,
         16'sd202,   16'sd103,   -16'sd23,  -16'sd122,   -16'sd151,
        -16'sd87,     16'sd57,   16'sd243,   16'sd419,    16'sd537,
         16'sd568,   16'sd506,   16'sd374,   16'sd209,     16'sd50,
        -16'sd70,   -16'sd135,  -16'sd146,  -16'sd120,   -16'sd103
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } t_fir_state;

endpackage

`default_nettype wire

[rtl/core/fir_filter_181_tap.sv]
// fir_filter_181_tap: direct-form fir filter, one shared multiply-accumulate unit
// depends on fir181_pkg (tap table, widths, sequencer state type)
//
//   channel   direction  handshake               payload
//   input     in         i_valid / o_stall       i_sample_in  (SAMPLE_WIDTH, signed)
//   output    out        o_valid / i_stall       o_sample_out (32, signed)
//
// a request is not accepted until the previous one has finished: the sequencer
// issues each tap through the one multiplier and one memory read port, drains
// the multiply and accumulate stages, loads the output register and stores the
// sample, then returns to idle ready for the next
// reset (synchronous, active low) empties the delay line and drops any result
// a previous result still stalled at the end of drain holds the request there
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_181_tap #(
    parameter int TAPS         = 181,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        i_sample_in,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [fir181_pkg::OUT_W-1:0]        o_sample_out
);
    import fir181_pkg::*;

    // delay line geometry
    localparam int DEPTH  = TAPS - 1;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW     = $clog2(DEPTH + 1);
    localparam int CW     = $clog2(TAPS);
    // datapath widths: accumulator sized so the tap sum never wraps
    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + CW;
    localparam int SH_W   = ACC_W - OUT_SHIFT;

    // sequencer
    t_fir_state r_state, n_state;
    logic       accept;
    logic       issue;
    logic       finish;

    logic [CW-1:0]                  r_cnt;
    logic signed [SAMPLE_WIDTH-1:0] r_x;

    // circular delay line: write pointer at the oldest slot, fill count
    // marks how many previous samples exist (missing ones read as zero)
    logic signed [SAMPLE_WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]                  r_wptr;
    logic [AW-1:0]                  r_rptr;
    logic [FW-1:0]                  r_fill;
    logic [FW-1:0]                  r_left;
    logic signed [SAMPLE_WIDTH-1:0] r_rd;
    logic [AW-1:0]                  wptr_prev;
    logic [AW-1:0]                  rptr_prev;
    logic [AW-1:0]                  wptr_next;

    // stage 1: operand fetch
    logic                           r_s1_v;
    logic                           r_s1_is_x;
    logic                           r_s1_live;
    logic signed [COEF_W-1:0]       r_s1_coef;
    logic signed [SAMPLE_WIDTH-1:0] s1_opnd;

    // stage 2: product, stage 3: accumulate
    logic                           r_s2_v;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc;

    // output register
    logic                           r_out_valid;
    logic signed [OUT_W-1:0]        r_out;
    logic signed [OUT_W-1:0]        shifted;

    // pointer arithmetic with wrap at the delay line depth
    assign wptr_prev = (r_wptr == '0) ? AW'(DEPTH - 1) : r_wptr - 1'b1;
    assign rptr_prev = (r_rptr == '0) ? AW'(DEPTH - 1) : r_rptr - 1'b1;
    assign wptr_next = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;

    // next state and handshake
    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        accept  = 1'b0;
        issue   = 1'b0;
        finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    accept  = 1'b1;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                issue = 1'b1;
                if (r_cnt == CW'(TAPS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the pipe to empty and the output register to free up
                if (!r_s1_v && !r_s2_v && (!r_out_valid || !i_stall)) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // tap counter, sample capture and read walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= '0;
        end else if (issue) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= i_sample_in;
            r_rptr <= wptr_prev;
            r_left <= r_fill;
        end else if (issue && (r_cnt != '0)) begin
            r_rptr <= rptr_prev;
            if (r_left != '0) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // delay line memory: one registered read, one write per request
    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_rptr];
        if (finish) begin
            mem[r_wptr] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_fill <= '0;
        end else if (finish) begin
            r_wptr <= wptr_next;
            if (r_fill != FW'(DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_coef <= TAP_TABLE[r_cnt];
            r_s1_is_x <= (r_cnt == '0);
            r_s1_live <= (r_left != '0);
        end
    end

    // tap 0 takes the new sample, older slots never written count as zero
    assign s1_opnd = r_s1_is_x ? r_x : (r_s1_live ? r_rd : '0);

    // stage 2: the shared multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_prod <= s1_opnd * r_s1_coef;
        end
    end

    // stage 3: accumulator
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc <= '0;
        end else if (r_s2_v) begin
            r_acc <= r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // arithmetic shift right, then keep or sign-extend to the result width
    generate
        if (SH_W >= OUT_W) begin : g_out_trunc
            assign shifted = r_acc[OUT_SHIFT +: OUT_W];
        end else begin : g_out_sext
            assign shifted = {{(OUT_W - SH_W){r_acc[ACC_W-1]}}, r_acc[ACC_W-1:OUT_SHIFT]};
        end
    endgenerate

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= shifted;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

endmodule

`default_nettype wire

[rtl/core/fir181_checker.sv]
// fir181_checker: port-level checks for fir_filter_181_tap, bound to the top level
// depends only on the top level's ports
`timescale 1ns / 1ps
`default_nettype none

module fir181_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_sample_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_sample_out))
        else $error("result changed while stalled");

    // an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after accepting a request");

    // the block only goes ready again once its result is posted
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) |-> o_valid)
        else $error("ready without a posted result");

    // a new result only appears at the end of a busy period
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result posted while idle");

endmodule

bind fir_filter_181_tap fir181_checker u_fir181_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_sample_out (o_sample_out)
);

`default_nettype wire
